// File: hdl/svptw_pkg.sv
package svptw_pkg;

  localparam int unsigned PTE_W      = 64;
  localparam int unsigned VA_W       = 39;
  localparam int unsigned ROOT_W     = 44;
  localparam int unsigned WIDX_W     = 12;
  localparam int unsigned VPN_W      = 9;
  localparam int unsigned PPN_LSB    = 10;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned SLOT_W     = 16;

  // PTE flag bit positions
  localparam int unsigned FLAG_V = 0;
  localparam int unsigned FLAG_R = 1;
  localparam int unsigned FLAG_W = 2;
  localparam int unsigned FLAG_X = 3;
  localparam int unsigned FLAG_U = 4;

  // input tdata layout, lowest bit up
  localparam int unsigned IN_TDATA_W = 120;
  localparam int unsigned IN_WIDX_LSB = 0;
  localparam int unsigned IN_WORD_LSB = IN_WIDX_LSB + WIDX_W;
  localparam int unsigned IN_VA_LSB   = IN_WORD_LSB + PTE_W;
  localparam int unsigned IN_USER_BIT = IN_VA_LSB + VA_W;

  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - PTE_W - 4;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_WALK  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_USER    = 2'd2,
    ST_NOLEAF  = 2'd3
  } status_e;

  typedef enum logic {
    WS_IDLE,
    WS_WALK
  } walk_state_e;

  // classified command handed from front to back
  typedef struct packed {
    logic              is_walk;
    logic [SLOT_W-1:0] slot;     // write slot, or level 2 slot of a walk
    logic [PTE_W-1:0]  data;
    logic [VA_W-1:0]   va;
    logic              user;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       level;
    status_e          status;
    logic [PTE_W-1:0] pa;
  } result_t;

endpackage

// File: hdl/sv39_page_table_walker.sv
// Channel     Dir  Handshake                     Payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: item fields
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: paddr, status, leaf_level
// cfg         in   cfg_valid_i/cfg_ready_o       cfg_data_i: root_page_number
//
// A write item is done in the walker as it is popped; a translation makes one
// registered table read per level, the first on its pop; no item is popped mid-walk.
// Front register and a 2-entry queue decouple intake from the walker.
// Reset clears control state only; the table store is undefined until written.
// Results wait in an output register; the walker stalls only while it is full.
module sv39_page_table_walker #(
  parameter int unsigned TABLE_WORDS = 4096  // power of two, 512 to 65536
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [0] action
  input  logic                                  s_axis_tuser,
  // [11:0] word_index, [75:12] entry_word, [114:76] virt_addr,
  // [115] user_request, [119:116] zero
  input  logic [svptw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [63:0] paddr, [65:64] status, [67:66] leaf_level, [71:68] zero
  output logic [svptw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [svptw_pkg::ROOT_W-1:0]          cfg_data_i
);

  localparam int unsigned AW = $clog2(TABLE_WORDS);

  logic [svptw_pkg::ROOT_W-1:0] root_q;
  logic                         f_valid, f_ready, q_valid, q_ready;
  svptw_pkg::cmd_t              f_cmd, q_cmd;
  svptw_pkg::result_t           res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_q <= cfg_data_i;
    end
  end

  svptw_front #(.AW(AW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .root_i      (root_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  svptw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  svptw_walker #(.AW(AW)) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{svptw_pkg::OUT_PAD_W{1'b0}}, res.level, res.status, res.pa};

endmodule

// File: hdl/svptw_front.sv
module svptw_front #(
  parameter int unsigned AW = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [svptw_pkg::ROOT_W-1:0]         root_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 in_action_i,
  input  logic [svptw_pkg::IN_TDATA_W-1:0]     in_data_i,
  output logic                                 cmd_valid_o,
  input  logic                                 cmd_ready_i,
  output svptw_pkg::cmd_t                      cmd_o
);

  logic                               valid_q;
  svptw_pkg::cmd_t                    cmd_q, cmd_d;
  logic [svptw_pkg::WIDX_W-1:0]       widx;
  logic [svptw_pkg::VA_W-1:0]         va;
  logic [AW+svptw_pkg::WIDX_W-1:0]    wext;
  logic [AW+svptw_pkg::VPN_W-1:0]     rext;
  logic [AW-1:0]                      slot;

  assign widx = in_data_i[svptw_pkg::IN_WIDX_LSB +: svptw_pkg::WIDX_W];
  assign va   = in_data_i[svptw_pkg::IN_VA_LSB +: svptw_pkg::VA_W];

  // word index wraps to the store depth; root slot is root*512 + VPN2
  assign wext = {{AW{1'b0}}, widx};
  assign rext = {root_i[AW-1:0], va[svptw_pkg::VA_W-1 -: svptw_pkg::VPN_W]};

  always_comb begin
    if (in_action_i == svptw_pkg::ACT_WALK) begin
      slot = rext[AW-1:0];
    end else begin
      slot = wext[AW-1:0];
    end
    cmd_d.is_walk = (in_action_i == svptw_pkg::ACT_WALK);
    cmd_d.slot    = svptw_pkg::SLOT_W'(slot);
    cmd_d.data    = in_data_i[svptw_pkg::IN_WORD_LSB +: svptw_pkg::PTE_W];
    cmd_d.va      = va;
    cmd_d.user    = in_data_i[svptw_pkg::IN_USER_BIT];
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: hdl/svptw_queue.sv
module svptw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  svptw_pkg::cmd_t in_cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output svptw_pkg::cmd_t out_cmd_o
);

  svptw_pkg::cmd_t                    entry_q [svptw_pkg::QUEUE_DEPTH];
  logic [svptw_pkg::QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [svptw_pkg::QUEUE_CNT_W-1:0]  count_q, count_d;
  logic                               push, pop;

  assign in_ready_o  = (count_q != svptw_pkg::QUEUE_CNT_W'(svptw_pkg::QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_cmd_o   = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// File: hdl/svptw_walker.sv
module svptw_walker #(
  parameter int unsigned AW = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  svptw_pkg::cmd_t                   cmd_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output svptw_pkg::result_t                res_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [svptw_pkg::PTE_W-1:0] mem [DEPTH];
  logic [svptw_pkg::PTE_W-1:0] rdata_q;

  svptw_pkg::walk_state_e       state_q, state_d;
  logic [1:0]                   level_q, level_d;
  logic [svptw_pkg::VA_W-1:0]   va_q;
  logic                         user_q;

  logic                         out_valid_q;
  svptw_pkg::result_t           out_q, res_d;
  logic                         out_free, load_out;

  logic                         pop, pop_walk, wr_en, rd_en, done;
  logic [AW-1:0]                rd_addr;
  logic                         pte_v, pte_leaf, user_fault;
  logic [svptw_pkg::VPN_W-1:0]  next_idx;
  logic [AW+svptw_pkg::VPN_W-1:0] next_ext;
  logic [svptw_pkg::PTE_W-1:0]  offset, leaf_pa;

  assign out_free = !out_valid_q || res_ready_i;
  assign pop      = cmd_valid_i && cmd_ready_o;
  assign pop_walk = pop && cmd_i.is_walk;

  // PTE decode on the word read for the current level
  assign pte_v      = rdata_q[svptw_pkg::FLAG_V];
  assign pte_leaf   = |rdata_q[svptw_pkg::FLAG_X:svptw_pkg::FLAG_R];
  assign user_fault = user_q && !rdata_q[svptw_pkg::FLAG_U];
  assign done       = !pte_v || pte_leaf || (level_q == 2'd0);

  always_comb begin
    case (level_q)
      2'd2:    next_idx = va_q[29:21];
      default: next_idx = va_q[20:12];
    endcase
  end
  assign next_ext = {rdata_q[svptw_pkg::PPN_LSB +: AW], next_idx};

  always_comb begin
    case (level_q)
      2'd2:    offset = {{(svptw_pkg::PTE_W-30){1'b0}}, va_q[29:0]};
      2'd1:    offset = {{(svptw_pkg::PTE_W-21){1'b0}}, va_q[20:0]};
      default: offset = {{(svptw_pkg::PTE_W-12){1'b0}}, va_q[11:0]};
    endcase
  end
  assign leaf_pa = {rdata_q[svptw_pkg::PTE_W-3:svptw_pkg::PPN_LSB],
                    {svptw_pkg::PAGE_SHIFT{1'b0}}} | offset;

  // next state
  always_comb begin
    state_d = state_q;
    level_d = level_q;
    case (state_q)
      svptw_pkg::WS_IDLE: begin
        if (pop_walk) begin
          state_d = svptw_pkg::WS_WALK;
          level_d = 2'd2;
        end
      end
      svptw_pkg::WS_WALK: begin
        if (done) begin
          state_d = svptw_pkg::WS_IDLE;
        end else begin
          level_d = level_q - 2'd1;
        end
      end
      default: state_d = svptw_pkg::WS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_ready_o  = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cmd_i.slot[AW-1:0];
    load_out     = 1'b0;
    res_d.pa     = '0;
    res_d.status = svptw_pkg::ST_OK;
    res_d.level  = 2'd0;
    case (state_q)
      svptw_pkg::WS_IDLE: begin
        cmd_ready_o = out_free;
        if (pop && !cmd_i.is_walk) begin
          wr_en    = 1'b1;
          load_out = 1'b1;
        end
        rd_en = pop_walk;
      end
      svptw_pkg::WS_WALK: begin
        res_d.level = level_q;
        if (!pte_v) begin
          res_d.status = svptw_pkg::ST_INVALID;
        end else if (pte_leaf && user_fault) begin
          res_d.status = svptw_pkg::ST_USER;
        end else if (pte_leaf) begin
          res_d.pa = leaf_pa;
        end else begin
          res_d.status = svptw_pkg::ST_NOLEAF;
        end
        load_out = done;
        rd_en    = !done;
        rd_addr  = next_ext[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cmd_i.slot[AW-1:0]] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svptw_pkg::WS_IDLE;
      level_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_walk) begin
      va_q   <= cmd_i.va;
      user_q <= cmd_i.user;
    end
    if (load_out) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule
